[sv/assert_macros.svh]
// assertion macros used by the port checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("check failed");

// next-cycle implication
`define CHK_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("check failed");

`endif

[sv/lzwe_pkg.sv]
// ----------------------------------------------------------------------------
// lzwe_pkg
// Types, sizes and command/status groups of the lzw byte encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

  localparam int DICT_ENTRIES   = 4096;
  localparam int MAX_STRING_LEN = 32;
  localparam int CODE_W = 13;
  localparam int LEN_W  = 6;
  localparam int IDX_W  = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(DICT_ENTRIES + 1);
  // hash table has twice the dictionary's slots, so a probe always ends
  localparam int TBL_W  = IDX_W + 1;
  localparam int TBL_DEPTH = 1 << TBL_W;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_out;
    logic              is_last;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] prefix;
    logic [7:0]        suffix;
    logic [IDX_W-1:0]  idx;
  } slot_t;

  typedef struct packed {
    logic clear_wr;
    logic take;
    logic rd;
    logic probe_next;
    logic grow;
    logic emit_cur;
    logic insert;
    logic restart;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic len_zero;
    logic len_max;
    logic hit;
    logic empty;
    logic room;
    logic eos;
    logic out_free;
  } status_t;

  function automatic logic [TBL_W-1:0] slot_hash(logic [CODE_W-1:0] code,
                                                 logic [7:0] b);
    logic [CODE_W+7:0] mix;
    mix = {8'd0, code} ^ ({{CODE_W{1'b0}}, b} << 4) ^
          ({{CODE_W{1'b0}}, b} * (CODE_W+8)'(7));
    return mix[TBL_W-1:0];
  endfunction

endpackage

[sv/lzwe_ctrl.sv]
// ----------------------------------------------------------------------------
// lzwe_ctrl
// Sequencer: table clear, hashed probe, grow / emit / insert, final flush.
// ----------------------------------------------------------------------------
module lzwe_ctrl import lzwe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_LOOK   = 7'b0001000,
    S_CMP    = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_LAST   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.len_zero) begin
          cmd.restart = 1'b1;
          state_next = st.eos ? S_LAST : S_IDLE;
        end else if (st.len_max) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.rd = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (st.hit) begin
          cmd.grow = 1'b1;
          state_next = st.eos ? S_LAST : S_IDLE;
        end else if (st.empty) begin
          state_next = S_EMIT;
        end else begin
          cmd.probe_next = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_cur = 1'b1;
          // string not found and under the limit: add it while there is room
          cmd.insert = !st.len_max && st.room;
          cmd.restart = 1'b1;
          state_next = st.eos ? S_LAST : S_IDLE;
        end
      end
      S_LAST: begin
        if (st.out_free) begin
          cmd.emit_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[sv/lzwe_datapath.sv]
// ----------------------------------------------------------------------------
// lzwe_datapath
// String registers, hash table memory, entry count and output register.
// ----------------------------------------------------------------------------
module lzwe_datapath import lzwe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output status_t   st,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  slot_t tbl [TBL_DEPTH];
  slot_t rd_data;

  logic [TBL_W-1:0]  slot;
  logic [CODE_W-1:0] cur_code;
  logic [LEN_W-1:0]  cur_len;
  logic [CNT_W-1:0]  count;
  logic [7:0]        byte_r;
  logic              eos_r;
  slot_t             wr_data;

  always_comb begin
    wr_data = '0;
    if (cmd.insert) begin
      wr_data.valid  = 1'b1;
      wr_data.prefix = cur_code;
      wr_data.suffix = byte_r;
      wr_data.idx    = count[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr || cmd.insert) tbl[slot] <= wr_data;
    if (cmd.rd) rd_data <= tbl[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= in_item.byte_in;
      eos_r  <= in_item.end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      cur_code <= '0;
      cur_len  <= '0;
      count    <= '0;
    end else begin
      if (cmd.clear_wr || cmd.probe_next) slot <= slot + 1'b1;
      if (cmd.take) slot <= slot_hash(cur_code, in_item.byte_in);
      if (cmd.insert) count <= count + 1'b1;
      if (cmd.grow) begin
        cur_code <= CODE_W'(256) + CODE_W'(rd_data.idx);
        cur_len  <= cur_len + 1'b1;
      end
      if (cmd.restart) begin
        cur_code <= CODE_W'(byte_r);
        cur_len  <= LEN_W'(1);
      end
      if (cmd.emit_last) begin
        cur_code <= '0;
        cur_len  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_cur || cmd.emit_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_cur || cmd.emit_last) begin
      out_item.code_out <= cur_code;
      out_item.is_last  <= cmd.emit_last;
    end
  end

  always_comb begin
    st.clear_done = (slot == {TBL_W{1'b1}});
    st.len_zero   = (cur_len == '0);
    st.len_max    = (cur_len == LEN_W'(MAX_STRING_LEN));
    st.hit        = rd_data.valid && rd_data.prefix == cur_code && rd_data.suffix == byte_r;
    st.empty      = !rd_data.valid;
    st.room       = (count < CNT_W'(DICT_ENTRIES));
    st.eos        = eos_r;
    st.out_free   = !out_valid || !out_stall;
  end

endmodule

[sv/lzw_byte_encoder_core.sv]
// flow: one byte at a time; a byte is registered, then the string is started if
// empty, emitted at the length limit, or else looked up in the hash table by its
// registered read along the linear probe chain until a hit or an empty slot
// ends it; an emit waits while the output is stalled, and byte_stall stays high
// until the byte is done. reset: a clearing pass sweeps every hash table slot,
// byte_stall stays high until it ends
// ----------------------------------------------------------------------------
// lzw_byte_encoder_core
// LZW compressor top level: controller plus datapath.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_core import lzwe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_item_t  byte_data,
  output logic      code_valid,
  input  logic      code_stall,
  output out_item_t code_data
);

  cmd_t    cmd;
  status_t st;
  logic    ready;

  assign byte_stall = !ready;

  lzwe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_valid),
    .ready    (ready),
    .st       (st),
    .cmd      (cmd)
  );

  lzwe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (byte_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (code_valid),
    .out_stall (code_stall),
    .out_item  (code_data)
  );

endmodule

[sv/lzwe_checker.sv]
// ----------------------------------------------------------------------------
// lzwe_port_checks
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzwe_port_checks import lzwe_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      byte_valid,
  input logic      byte_stall,
  input in_item_t  byte_data,
  input logic      code_valid,
  input logic      code_stall,
  input out_item_t code_data
);

  `CHK_IMPL(a_clear_after_rst, clk, rst, $past(rst), byte_stall)
  `CHK_NEXT(a_one_at_a_time, clk, rst, byte_valid && !byte_stall, byte_stall)
  `CHK_NEXT(a_code_held, clk, rst, code_valid && code_stall, code_valid)
  `CHK_NEXT(a_code_stable, clk, rst, code_valid && code_stall, $stable(code_data))

endmodule

bind lzw_byte_encoder_core lzwe_port_checks u_chk (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_data  (byte_data),
  .code_valid (code_valid),
  .code_stall (code_stall),
  .code_data  (code_data)
);
